// File: rtl/core/rthsl_pkg.sv
package rthsl_pkg;

    localparam int unsigned CH_W      = 8;
    localparam int unsigned HUE_W     = 9;
    localparam int unsigned PCT_W     = 7;
    localparam int unsigned SUM_W     = 9;
    localparam int unsigned REM_W     = 18;  // 2*hue*d + d stays below 2^18
    localparam int unsigned DIVR_W    = 9;   // divisors are 2*d or 2*den, at most 510
    localparam int unsigned QUO_W     = 9;   // one quotient bit per divider stage
    localparam int unsigned DIV_STEPS = QUO_W;
    localparam int unsigned LX_W      = 14;  // 20*sum + 51
    localparam int unsigned LPROD_W   = 28;

    localparam int unsigned CH_MAX    = 255;
    localparam int unsigned SUM_FULL  = 510;
    localparam int unsigned LX_BIAS   = 51;
    // floor(x/102) == (x * LRECIP) >> LSHIFT for all x below 12192
    localparam int unsigned LRECIP    = 10281;
    localparam int unsigned LSHIFT    = 20;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0] hue_deg;
        logic [PCT_W-1:0] sat_pct;
        logic [PCT_W-1:0] light_pct;
    } hsl_t;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // payload moving through the divider chain
    typedef struct packed {
        logic [REM_W-1:0]  hue_rem;
        logic [DIVR_W-1:0] hue_div;
        logic [QUO_W-1:0]  hue_quo;
        logic [REM_W-1:0]  sat_rem;
        logic [DIVR_W-1:0] sat_div;
        logic [QUO_W-1:0]  sat_quo;
        logic [LX_W-1:0]   light_x;
    } div_t;

endpackage

// File: rtl/core/rthsl_prep.sv
module rthsl_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  rthsl_pkg::pixel_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rthsl_pkg::div_t     out_data
);

    // stage 1: extremes and sector
    logic                        v1_reg;
    logic [rthsl_pkg::CH_W-1:0]  mx1_reg, mn1_reg;
    logic [rthsl_pkg::CH_W-1:0]  r1_reg, g1_reg, b1_reg;
    rthsl_pkg::sector_t          sec1_reg;
    // stage 2: sum, spread, sector difference
    logic                        v2_reg;
    logic [rthsl_pkg::SUM_W-1:0] sum2_reg;
    logic [rthsl_pkg::CH_W-1:0]  d2_reg;
    logic signed [8:0]           diff2_reg;
    rthsl_pkg::sector_t          sec2_reg;
    // stage 3: dividends and divisors
    logic                        v3_reg;
    rthsl_pkg::div_t             d3_reg;

    logic en1, en2, en3;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1 combinational
    logic [rthsl_pkg::CH_W-1:0] mx1_next, mn1_next;
    rthsl_pkg::sector_t         sec1_next;

    always_comb begin
        mx1_next = in_data.red_in;
        mn1_next = in_data.red_in;
        if (in_data.green_in > mx1_next) mx1_next = in_data.green_in;
        if (in_data.blue_in  > mx1_next) mx1_next = in_data.blue_in;
        if (in_data.green_in < mn1_next) mn1_next = in_data.green_in;
        if (in_data.blue_in  < mn1_next) mn1_next = in_data.blue_in;
        if (in_data.red_in > in_data.green_in) begin
            sec1_next = (in_data.red_in > in_data.blue_in) ? rthsl_pkg::SEC_RED
                                                           : rthsl_pkg::SEC_BLUE;
        end else begin
            sec1_next = (in_data.green_in > in_data.blue_in) ? rthsl_pkg::SEC_GREEN
                                                             : rthsl_pkg::SEC_BLUE;
        end
    end

    // stage 2 combinational
    logic signed [8:0] diff2_next;

    always_comb begin
        unique case (sec1_reg)
            rthsl_pkg::SEC_RED:   diff2_next = $signed({1'b0, g1_reg}) - $signed({1'b0, b1_reg});
            rthsl_pkg::SEC_GREEN: diff2_next = $signed({1'b0, b1_reg}) - $signed({1'b0, r1_reg});
            default:              diff2_next = $signed({1'b0, r1_reg}) - $signed({1'b0, g1_reg});
        endcase
    end

    // stage 3 combinational
    logic [rthsl_pkg::SUM_W-1:0] den;
    logic [9:0]                  kd;
    logic signed [11:0]          tpos;
    logic signed [18:0]          hd_raw, hd;
    logic [18:0]                 wrap;
    rthsl_pkg::div_t             d3_next;

    always_comb begin
        den = (sum2_reg < rthsl_pkg::SUM_W'(rthsl_pkg::CH_MAX)) ? sum2_reg
            : rthsl_pkg::SUM_W'(rthsl_pkg::SUM_FULL) - sum2_reg;
        unique case (sec2_reg)
            rthsl_pkg::SEC_RED:   kd = 10'd0;
            rthsl_pkg::SEC_GREEN: kd = {1'b0, d2_reg, 1'b0};
            default:              kd = {d2_reg, 2'b00};
        endcase
        tpos   = $signed({{3{diff2_reg[8]}}, diff2_reg}) + $signed({2'b00, kd});
        // 60*t = 64*t - 4*t
        hd_raw = ($signed({{7{tpos[11]}}, tpos}) <<< 6) - ($signed({{7{tpos[11]}}, tpos}) <<< 2);
        // 360*d = 256d + 64d + 32d + 8d
        wrap   = 19'({d2_reg, 8'b0}) + 19'({d2_reg, 6'b0}) + 19'({d2_reg, 5'b0})
               + 19'({d2_reg, 3'b0});
        hd     = hd_raw[18] ? hd_raw + $signed(wrap) : hd_raw;

        d3_next.hue_quo = '0;
        d3_next.sat_quo = '0;
        d3_next.light_x = rthsl_pkg::LX_W'({sum2_reg, 4'b0}) + rthsl_pkg::LX_W'({sum2_reg, 2'b0})
                        + rthsl_pkg::LX_W'(rthsl_pkg::LX_BIAS);
        if (d2_reg == '0) begin
            // grey: zero dividend gives zero hue and saturation
            d3_next.hue_rem = '0;
            d3_next.hue_div = rthsl_pkg::DIVR_W'(2);
            d3_next.sat_rem = '0;
            d3_next.sat_div = rthsl_pkg::DIVR_W'(2);
        end else begin
            // round(n/m) = floor((2n + m) / 2m)
            d3_next.hue_rem = rthsl_pkg::REM_W'({hd[16:0], 1'b0})
                            + rthsl_pkg::REM_W'(d2_reg);
            d3_next.hue_div = {d2_reg, 1'b0};
            // 200*d = 128d + 64d + 8d
            d3_next.sat_rem = rthsl_pkg::REM_W'({d2_reg, 7'b0})
                            + rthsl_pkg::REM_W'({d2_reg, 6'b0})
                            + rthsl_pkg::REM_W'({d2_reg, 3'b0})
                            + rthsl_pkg::REM_W'(den);
            d3_next.sat_div = {den[7:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            mx1_reg  <= mx1_next;
            mn1_reg  <= mn1_next;
            sec1_reg <= sec1_next;
            r1_reg   <= in_data.red_in;
            g1_reg   <= in_data.green_in;
            b1_reg   <= in_data.blue_in;
        end
        if (en2) begin
            sum2_reg  <= rthsl_pkg::SUM_W'(mx1_reg) + rthsl_pkg::SUM_W'(mn1_reg);
            d2_reg    <= mx1_reg - mn1_reg;
            diff2_reg <= diff2_next;
            sec2_reg  <= sec1_reg;
        end
        if (en3) begin
            d3_reg <= d3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = d3_reg;

endmodule

// File: rtl/core/rthsl_div_stage.sv
module rthsl_div_stage #(
    parameter int unsigned STEP = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rthsl_pkg::div_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rthsl_pkg::div_t  out_data
);

    logic            v_reg;
    rthsl_pkg::div_t d_reg, d_next;
    logic [rthsl_pkg::REM_W-1:0] hue_sh, sat_sh;
    logic en;

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    // one restoring step per lane, quotient bit STEP
    always_comb begin
        d_next = in_data;
        hue_sh = rthsl_pkg::REM_W'(in_data.hue_div) << STEP;
        sat_sh = rthsl_pkg::REM_W'(in_data.sat_div) << STEP;
        if (in_data.hue_rem >= hue_sh) begin
            d_next.hue_rem       = in_data.hue_rem - hue_sh;
            d_next.hue_quo[STEP] = 1'b1;
        end
        if (in_data.sat_rem >= sat_sh) begin
            d_next.sat_rem       = in_data.sat_rem - sat_sh;
            d_next.sat_quo[STEP] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = d_reg;

endmodule

// File: rtl/core/rgb_to_hsl_pixel_top.sv
// RGB to HSL pixel converter. Accepts one 8-bit RGB pixel per clock on the
// s_ channel while the output is not stalled and returns hue (0..360
// degrees), saturation and lightness (0..100 percent), each rounded to
// nearest with ties up, on the m_ channel in the same order. Throughput is
// one pixel per clock when the output is not stalled. A request passes three
// front-end stages (extremes and sector, sum and spread, dividends), nine
// restoring divider stages that retire one quotient bit each for hue and
// saturation, and the output register, where lightness is formed by a
// constant reciprocal multiply. Each stage has its own valid bit and takes a
// new request whenever it is empty or its successor moves, so bubbles fill in
// and a stalled output backs the pipe up one stage at a time. A grey pixel
// yields hue 0 and saturation 0; a red-sector hue just below a full turn can
// round up and is reported as 360.
module rgb_to_hsl_pixel_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rthsl_pkg::pixel_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rthsl_pkg::hsl_t     m_data
);

    localparam int unsigned N = rthsl_pkg::DIV_STEPS;

    // link k feeds divider stage k; link N feeds the output register
    logic            link_valid [N+1];
    logic            link_ready [N+1];
    rthsl_pkg::div_t link_data  [N+1];

    // front end: max/min, sector, sum, spread, dividends
    rthsl_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_data  (link_data[0])
    );

    // divider chain, most significant quotient bit first
    for (genvar k = 0; k < N; k++) begin : g_div
        rthsl_div_stage #(
            .STEP (N - 1 - k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    // output register
    logic                               out_valid_reg;
    rthsl_pkg::hsl_t                    out_data_reg, out_data_next;
    logic [rthsl_pkg::LPROD_W-1:0]      light_prod;
    logic                               out_en;

    assign out_en       = !out_valid_reg || m_ready;
    assign link_ready[N] = out_en;

    always_comb begin
        // lightness = floor((20*sum + 51) / 102)
        light_prod = rthsl_pkg::LPROD_W'(link_data[N].light_x)
                   * rthsl_pkg::LPROD_W'(rthsl_pkg::LRECIP);
        out_data_next.hue_deg   = link_data[N].hue_quo[rthsl_pkg::HUE_W-1:0];
        out_data_next.sat_pct   = link_data[N].sat_quo[rthsl_pkg::PCT_W-1:0];
        out_data_next.light_pct =
            light_prod[rthsl_pkg::LSHIFT +: rthsl_pkg::PCT_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_en) begin
            out_valid_reg <= link_valid[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: rtl/core/rthsl_checker.sv
module rthsl_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input rthsl_pkg::hsl_t  m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // results stay in range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hue_deg <= 9'd360) && (m_data.sat_pct <= 7'd100)
                    && (m_data.light_pct <= 7'd100))
        else $error("result field out of range");

    // pipe only refuses requests when the output is stalled
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input refused while output free");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rgb_to_hsl_pixel_top rthsl_checker u_rthsl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
